// ===== rtl/core/olac_pkg.sv =====
// Shared types, register codes and coil tables for the occupancy light actuator controller.
// No dependencies; imported by the top level, the front and back ends and the bench.
package olac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WAKE_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INACT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_GO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_BACK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RETRACT_STEPS = 3'd6;

    localparam logic [7:0] RST_WAKE_PERIOD   = 8'd67;
    localparam logic [4:0] RST_INACT_LIMIT   = 5'd15;
    localparam logic [8:0] RST_SHORT_PRESS   = 9'd100;
    localparam logic [8:0] RST_LONG_CAP      = 9'd500;
    localparam logic [7:0] RST_STEPS_GO      = 8'd25;
    localparam logic [7:0] RST_STEPS_BACK    = 8'd45;
    localparam logic [7:0] RST_RETRACT_STEPS = 8'd120;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_LONG  = 2'd1;
    localparam logic [1:0] EV_SHORT = 2'd2;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    typedef struct packed {
        logic [7:0] wake_period;
        logic [4:0] inact_limit;
        logic [8:0] short_press;
        logic [8:0] long_cap;
        logic [7:0] steps_go;
        logic [7:0] steps_back;
        logic [7:0] retract_steps;
    } t_cfg;

    typedef struct packed {
        logic [1:0] press_report;
        logic       sensor;
    } t_tick;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic       light_is_on;
        logic       auto_mode;
        logic       motor_busy;
    } t_result;

    typedef struct packed {
        logic [8:0] q0;
        logic [8:0] q1;
    } t_mq;

    function automatic t_mq enqueue(input t_mq q, input logic rev, input logic [7:0] steps);
        t_mq r;
        r = q;
        if (steps != 8'd0) begin
            if (q.q0 == 9'd0) begin
                r.q0 = {rev, steps};
            end else if (q.q1 == 9'd0) begin
                r.q1 = {rev, steps};
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] fwd_coil(input logic [2:0] ph);
        logic [3:0] c;
        case (ph)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hC;
            3'd6: c = 4'h8;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] rev_coil(input logic [2:0] ph);
        logic [3:0] c;
        case (ph)
            3'd0: c = 4'h8;
            3'd1: c = 4'hC;
            3'd2: c = 4'h4;
            3'd3: c = 4'h6;
            3'd4: c = 4'h2;
            3'd5: c = 4'h3;
            3'd6: c = 4'h1;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/occupancy_light_actuator_controller_top.sv =====
// Top level of the occupancy light actuator controller: register file, front and back ends.
// Depends on olac_pkg, olac_front and olac_back.
//
//   channel  | handshake        | words
//   ---------+------------------+-------------------------------------------------
//   tick in  | push / full      | i_touch_level, i_sensor_level
//   result   | pop / empty      | o_coil_pattern, o_light_is_on, o_auto_mode, o_motor_busy
//   config   | i_cfg_wr_en      | i_cfg_index, i_cfg_data
//
// One tick word is taken per cycle while full is low; its result word passes through the
// front queue and then the result queue before it reaches the result ports.
// The front holds two classified ticks, the back holds two result words, so each
// side stalls on its own; full rises only once both queues are full.
// Synchronous reset clears all state but the queue storage and loads the register defaults.
module occupancy_light_actuator_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic       i_touch_level,
    input  logic       i_sensor_level,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_coil_pattern,
    output logic       o_light_is_on,
    output logic       o_auto_mode,
    output logic       o_motor_busy
);
    import olac_pkg::*;

    t_cfg    r_cfg;
    t_tick   tick;
    logic    tick_valid;
    logic    tick_take;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wake_period   <= RST_WAKE_PERIOD;
            r_cfg.inact_limit   <= RST_INACT_LIMIT;
            r_cfg.short_press   <= RST_SHORT_PRESS;
            r_cfg.long_cap      <= RST_LONG_CAP;
            r_cfg.steps_go      <= RST_STEPS_GO;
            r_cfg.steps_back    <= RST_STEPS_BACK;
            r_cfg.retract_steps <= RST_RETRACT_STEPS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_WAKE_PERIOD:   r_cfg.wake_period   <= i_cfg_data[7:0];
                REG_INACT_LIMIT:   r_cfg.inact_limit   <= i_cfg_data[4:0];
                REG_SHORT_PRESS:   r_cfg.short_press   <= i_cfg_data;
                REG_LONG_CAP:      r_cfg.long_cap      <= i_cfg_data;
                REG_STEPS_GO:      r_cfg.steps_go      <= i_cfg_data[7:0];
                REG_STEPS_BACK:    r_cfg.steps_back    <= i_cfg_data[7:0];
                REG_RETRACT_STEPS: r_cfg.retract_steps <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    olac_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_touch  (i_touch_level),
        .i_sensor (i_sensor_level),
        .o_full   (full),
        .o_valid  (tick_valid),
        .o_tick   (tick),
        .i_take   (tick_take)
    );

    olac_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (tick_valid),
        .i_tick   (tick),
        .o_take   (tick_take),
        .o_empty  (empty),
        .o_result (res),
        .i_pop    (pop)
    );

    assign o_coil_pattern = res.coil_pattern;
    assign o_light_is_on  = res.light_is_on;
    assign o_auto_mode    = res.auto_mode;
    assign o_motor_busy   = res.motor_busy;

endmodule

// ===== rtl/core/olac_front.sv =====
// Front end: takes tick words, classifies touch presses, and queues classified ticks.
// Depends on olac_pkg.
module olac_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  olac_pkg::t_cfg i_cfg,
    input  logic           i_push,
    input  logic           i_touch,
    input  logic           i_sensor,
    output logic           o_full,
    output logic           o_valid,
    output olac_pkg::t_tick o_tick,
    input  logic           i_take
);
    import olac_pkg::*;

    logic [8:0] r_press_ticks, n_press_ticks;
    logic       r_press_active, n_press_active;
    logic [1:0] report;
    t_tick      r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       acc;

    assign acc     = i_push && !o_full;
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_tick  = r_q[r_rd_ptr];

    always_comb begin
        n_press_ticks  = r_press_ticks;
        n_press_active = r_press_active;
        report         = EV_NONE;
        if (!r_press_active) begin
            if (i_touch) begin
                n_press_active = 1'b1;
                n_press_ticks  = 9'd0;
            end
        end else if (!i_touch) begin
            if (r_press_ticks < i_cfg.long_cap) begin
                report = (r_press_ticks < i_cfg.short_press) ? EV_SHORT : EV_LONG;
            end
            n_press_active = 1'b0;
        end else if (r_press_ticks < i_cfg.long_cap) begin
            n_press_ticks = r_press_ticks + 9'd1;
            if (n_press_ticks >= i_cfg.long_cap) begin
                report = (n_press_ticks < i_cfg.short_press) ? EV_SHORT : EV_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks  <= 9'd0;
            r_press_active <= 1'b0;
            r_wr_ptr       <= 1'b0;
            r_rd_ptr       <= 1'b0;
            r_count        <= 2'd0;
        end else begin
            if (acc) begin
                r_press_ticks  <= n_press_ticks;
                r_press_active <= n_press_active;
                r_wr_ptr       <= ~r_wr_ptr;
            end
            if (i_take && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, acc} - {1'b0, i_take && o_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr_ptr] <= '{press_report: report, sensor: i_sensor};
        end
    end

endmodule

// ===== rtl/core/olac_back.sv =====
// Back end: mode and light decisions, wake timer, stepper move queue and result queue.
// Depends on olac_pkg; fed by olac_front.
module olac_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  olac_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  olac_pkg::t_tick  i_tick,
    output logic             o_take,
    output logic             o_empty,
    output olac_pkg::t_result o_result,
    input  logic             i_pop
);
    import olac_pkg::*;

    logic [1:0] r_press_event, n_press_event;
    logic       r_last_sensor, n_last_sensor;
    logic       r_pass_pending, n_pass_pending;
    logic       r_mode_auto, n_mode_auto;
    logic       r_light, n_light;
    logic       r_waiting, n_waiting;
    logic [4:0] r_absence, n_absence;
    logic [7:0] r_wake_count, n_wake_count;
    logic       r_wake_running, n_wake_running;
    t_mq        r_mq, n_mq;
    logic [2:0] r_phase, n_phase;
    logic [7:0] r_steps_left, n_steps_left;
    logic [1:0] ev;
    logic       sens;
    logic       decide;
    t_result    res;
    t_result    r_rq [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_ok;

    assign o_take   = i_valid && (r_count != 2'd2);
    assign o_empty  = (r_count == 2'd0);
    assign o_result = r_rq[r_rd_ptr];
    assign pop_ok   = i_pop && !o_empty;
    assign sens     = i_tick.sensor;

    always_comb begin
        n_press_event  = (i_tick.press_report != EV_NONE) ? i_tick.press_report : r_press_event;
        n_last_sensor  = r_last_sensor;
        n_pass_pending = r_pass_pending;
        n_mode_auto    = r_mode_auto;
        n_light        = r_light;
        n_waiting      = r_waiting;
        n_absence      = r_absence;
        n_wake_count   = r_wake_count;
        n_wake_running = r_wake_running;
        n_mq           = r_mq;
        n_phase        = r_phase;
        n_steps_left   = r_steps_left;
        ev             = EV_NONE;
        res            = '0;

        // wake timer
        if (r_wake_running) begin
            n_wake_count = r_wake_count + 8'd1;
            if (n_wake_count >= i_cfg.wake_period || n_wake_count == 8'd0) begin
                n_wake_count   = 8'd0;
                n_pass_pending = 1'b1;
            end
        end

        decide = (r_steps_left == 8'd0) && (r_mq.q0 == 9'd0) &&
                 (n_press_event == EV_LONG || n_press_event == EV_SHORT ||
                  n_pass_pending || sens != r_last_sensor);

        if (decide) begin
            ev             = n_press_event;
            n_press_event  = EV_NONE;
            n_pass_pending = 1'b0;
            n_last_sensor  = sens;
            if (ev == EV_SHORT) begin
                if (!n_mode_auto) begin
                    if (n_light) begin
                        n_light = 1'b0;
                        n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_go);
                        n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_back);
                    end else begin
                        n_light = 1'b1;
                        n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_go);
                        n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_back);
                    end
                end
            end else if (ev == EV_LONG) begin
                if (n_mode_auto) begin
                    n_wake_running = 1'b0;
                    n_wake_count   = 8'd0;
                    n_pass_pending = 1'b0;
                    n_waiting      = 1'b0;
                    n_mode_auto    = 1'b0;
                    n_mq = enqueue(n_mq, DIR_REV, i_cfg.retract_steps);
                end else begin
                    n_mode_auto = 1'b1;
                    if (sens) begin
                        n_light = 1'b1;
                        n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_go);
                        n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_back);
                    end else begin
                        n_light = 1'b0;
                        n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_go);
                        n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_back);
                    end
                end
            end
            if (n_mode_auto) begin
                if (sens) begin
                    if (n_waiting) begin
                        n_wake_running = 1'b0;
                        n_wake_count   = 8'd0;
                        n_pass_pending = 1'b0;
                        n_waiting      = 1'b0;
                    end
                    if (!n_light) begin
                        n_light = 1'b1;
                        n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_go);
                        n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_back);
                    end
                end else begin
                    if (!n_waiting) begin
                        n_waiting      = 1'b1;
                        n_absence      = 5'd0;
                        n_wake_running = 1'b1;
                        n_wake_count   = 8'd0;
                    end
                    if (n_absence >= i_cfg.inact_limit) begin
                        n_wake_running = 1'b0;
                        n_wake_count   = 8'd0;
                        n_pass_pending = 1'b0;
                        if (n_light) begin
                            n_light = 1'b0;
                            n_mq = enqueue(n_mq, DIR_FWD, i_cfg.steps_go);
                            n_mq = enqueue(n_mq, DIR_REV, i_cfg.steps_back);
                        end
                    end else begin
                        n_absence = n_absence + 5'd1;
                    end
                end
            end
        end

        // motor drive
        if (n_steps_left == 8'd0 && n_mq.q0 != 9'd0) begin
            n_steps_left = n_mq.q0[7:0];
            n_phase      = 3'd0;
        end
        if (n_steps_left != 8'd0) begin
            res.coil_pattern = n_mq.q0[8] ? rev_coil(n_phase) : fwd_coil(n_phase);
            n_phase = n_phase + 3'd1;
            if (n_phase == 3'd0) begin
                n_steps_left = n_steps_left - 8'd1;
                if (n_steps_left == 8'd0) begin
                    n_mq.q0 = n_mq.q1;
                    n_mq.q1 = 9'd0;
                end
            end
        end

        res.light_is_on = n_light;
        res.auto_mode   = n_mode_auto;
        res.motor_busy  = (n_steps_left != 8'd0) || (n_mq.q0 != 9'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_event  <= EV_NONE;
            r_last_sensor  <= 1'b0;
            r_pass_pending <= 1'b0;
            r_mode_auto    <= 1'b0;
            r_light        <= 1'b0;
            r_waiting      <= 1'b0;
            r_absence      <= 5'd0;
            r_wake_count   <= 8'd0;
            r_wake_running <= 1'b0;
            r_mq           <= '0;
            r_phase        <= 3'd0;
            r_steps_left   <= 8'd0;
            r_wr_ptr       <= 1'b0;
            r_rd_ptr       <= 1'b0;
            r_count        <= 2'd0;
        end else begin
            if (o_take) begin
                r_press_event  <= n_press_event;
                r_last_sensor  <= n_last_sensor;
                r_pass_pending <= n_pass_pending;
                r_mode_auto    <= n_mode_auto;
                r_light        <= n_light;
                r_waiting      <= n_waiting;
                r_absence      <= n_absence;
                r_wake_count   <= n_wake_count;
                r_wake_running <= n_wake_running;
                r_mq           <= n_mq;
                r_phase        <= n_phase;
                r_steps_left   <= n_steps_left;
                r_wr_ptr       <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, o_take} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rq[r_wr_ptr] <= res;
        end
    end

endmodule

// ===== rtl/core/olac_checker.sv =====
// Port-level checks for the occupancy light actuator controller, bound to the top level.
// Depends only on the top level's ports.
module olac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_coil_pattern,
    input logic       o_light_is_on,
    input logic       o_auto_mode,
    input logic       o_motor_busy
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_half_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> $countones(o_coil_pattern) <= 2)
        else $error("coil pattern drives more than two coils");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting word dropped");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_coil_pattern) && $stable(o_light_is_on) &&
                           $stable(o_auto_mode) && $stable(o_motor_busy))
        else $error("waiting word changed");

endmodule

bind occupancy_light_actuator_controller_top olac_checker u_olac_checker (.*);

// ===== verif/tb.sv =====
// Self-checking bench for occupancy_light_actuator_controller_top: tick words in, result words out.
// Predicts each result word from its own shadow of the block state and compares field by field.
// Depends on olac_pkg and the top level of the block.
module tb;
    import olac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [31:0] FWD_SEQ = 32'h98C46231;
    localparam logic [31:0] REV_SEQ = 32'h913264C8;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [2:0] i_cfg_index;
    logic [8:0] i_cfg_data;
    logic       push;
    logic       full;
    logic       i_touch_level;
    logic       i_sensor_level;
    logic       empty;
    logic       pop;
    logic [3:0] o_coil_pattern;
    logic       o_light_is_on;
    logic       o_auto_mode;
    logic       o_motor_busy;

    occupancy_light_actuator_controller_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_touch_level  (i_touch_level),
        .i_sensor_level (i_sensor_level),
        .empty          (empty),
        .pop            (pop),
        .o_coil_pattern (o_coil_pattern),
        .o_light_is_on  (o_light_is_on),
        .o_auto_mode    (o_auto_mode),
        .o_motor_busy   (o_motor_busy)
    );

    // shadow registers
    logic [7:0] sh_wake_period;
    logic [4:0] sh_inact_limit;
    logic [8:0] sh_short_press;
    logic [8:0] sh_long_cap;
    logic [7:0] sh_steps_go;
    logic [7:0] sh_steps_back;
    logic [7:0] sh_retract;

    // predicted block state
    logic [8:0] pr_press_ticks;
    logic       pr_press_active;
    logic [1:0] pr_press_ev;
    logic       pr_last_sens;
    logic       pr_pass_pend;
    logic       pr_auto;
    logic       pr_light;
    logic       pr_waiting;
    logic [4:0] pr_absence;
    logic [7:0] pr_wake_cnt;
    logic       pr_wake_run;
    logic [8:0] pr_move0;
    logic [8:0] pr_move1;
    logic [2:0] pr_phase;
    logic [7:0] pr_steps_left;

    t_result actuator_words_due[$];
    int      err_count;
    int      items_sent;
    bit      idle_on;
    bit      hold_req;
    int      hold_left;
    int      pop_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("[occupancy_light_actuator_controller_top] ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic void clear_controller();
        sh_wake_period  = RST_WAKE_PERIOD;
        sh_inact_limit  = RST_INACT_LIMIT;
        sh_short_press  = RST_SHORT_PRESS;
        sh_long_cap     = RST_LONG_CAP;
        sh_steps_go     = RST_STEPS_GO;
        sh_steps_back   = RST_STEPS_BACK;
        sh_retract      = RST_RETRACT_STEPS;
        pr_press_ticks  = '0;
        pr_press_active = 1'b0;
        pr_press_ev     = EV_NONE;
        pr_last_sens    = 1'b0;
        pr_pass_pend    = 1'b0;
        pr_auto         = 1'b0;
        pr_light        = 1'b0;
        pr_waiting      = 1'b0;
        pr_absence      = '0;
        pr_wake_cnt     = '0;
        pr_wake_run     = 1'b0;
        pr_move0        = '0;
        pr_move1        = '0;
        pr_phase        = '0;
        pr_steps_left   = '0;
    endfunction

    function automatic void queue_move(input logic rev, input logic [7:0] steps);
        if (steps != 8'd0) begin
            if (pr_move0 == 9'd0) begin
                pr_move0 = {rev, steps};
            end else if (pr_move1 == 9'd0) begin
                pr_move1 = {rev, steps};
            end
        end
    endfunction

    function automatic void switch_light_on();
        if (!pr_light) begin
            pr_light = 1'b1;
            queue_move(DIR_REV, sh_steps_go);
            queue_move(DIR_FWD, sh_steps_back);
        end
    endfunction

    function automatic void switch_light_off();
        if (pr_light) begin
            pr_light = 1'b0;
            queue_move(DIR_FWD, sh_steps_go);
            queue_move(DIR_REV, sh_steps_back);
        end
    endfunction

    function automatic void stop_wake_timer();
        pr_wake_run  = 1'b0;
        pr_wake_cnt  = '0;
        pr_pass_pend = 1'b0;
    endfunction

    function automatic void classify_press();
        pr_press_ev = (pr_press_ticks < sh_short_press) ? EV_SHORT : EV_LONG;
    endfunction

    function automatic logic arm_moving();
        return (pr_steps_left != 8'd0) || (pr_move0 != 9'd0);
    endfunction

    function automatic t_result advance_controller(input logic touch, input logic sens);
        t_result    r;
        logic [1:0] ev;
        if (!pr_press_active) begin
            if (touch) begin
                pr_press_active = 1'b1;
                pr_press_ticks  = '0;
            end
        end else if (!touch) begin
            if (pr_press_ticks < sh_long_cap) classify_press();
            pr_press_active = 1'b0;
        end else if (pr_press_ticks < sh_long_cap) begin
            pr_press_ticks = pr_press_ticks + 9'd1;
            if (pr_press_ticks >= sh_long_cap) classify_press();
        end

        if (pr_wake_run) begin
            pr_wake_cnt = pr_wake_cnt + 8'd1;
            if (pr_wake_cnt >= sh_wake_period || pr_wake_cnt == 8'd0) begin
                pr_wake_cnt  = '0;
                pr_pass_pend = 1'b1;
            end
        end

        if (!arm_moving() && (pr_press_ev == EV_LONG || pr_press_ev == EV_SHORT ||
                              pr_pass_pend || sens != pr_last_sens)) begin
            ev           = pr_press_ev;
            pr_press_ev  = EV_NONE;
            pr_pass_pend = 1'b0;
            pr_last_sens = sens;
            if (ev == EV_SHORT) begin
                if (!pr_auto) begin
                    if (pr_light) switch_light_off();
                    else switch_light_on();
                end
            end else if (ev == EV_LONG) begin
                if (pr_auto) begin
                    stop_wake_timer();
                    pr_waiting = 1'b0;
                    pr_auto    = 1'b0;
                    queue_move(DIR_REV, sh_retract);
                end else begin
                    pr_auto = 1'b1;
                    if (sens) begin
                        pr_light = 1'b0;
                        switch_light_on();
                    end else begin
                        pr_light = 1'b1;
                        switch_light_off();
                    end
                end
            end
            if (pr_auto) begin
                if (sens) begin
                    if (pr_waiting) begin
                        stop_wake_timer();
                        pr_waiting = 1'b0;
                    end
                    switch_light_on();
                end else begin
                    if (!pr_waiting) begin
                        pr_waiting  = 1'b1;
                        pr_absence  = '0;
                        pr_wake_run = 1'b1;
                        pr_wake_cnt = '0;
                    end
                    if (pr_absence >= sh_inact_limit) begin
                        stop_wake_timer();
                        switch_light_off();
                    end else begin
                        pr_absence = pr_absence + 5'd1;
                    end
                end
            end
        end

        if (pr_steps_left == 8'd0 && pr_move0 != 9'd0) begin
            pr_steps_left = pr_move0[7:0];
            pr_phase      = '0;
        end
        r.coil_pattern = 4'h0;
        if (pr_steps_left != 8'd0) begin
            if (pr_move0[8] == DIR_REV) r.coil_pattern = REV_SEQ[{pr_phase, 2'b00} +: 4];
            else r.coil_pattern = FWD_SEQ[{pr_phase, 2'b00} +: 4];
            pr_phase = pr_phase + 3'd1;
            if (pr_phase == 3'd0) begin
                pr_steps_left = pr_steps_left - 8'd1;
                if (pr_steps_left == 8'd0) begin
                    pr_move0 = pr_move1;
                    pr_move1 = '0;
                end
            end
        end
        r.light_is_on = pr_light;
        r.auto_mode   = pr_auto;
        r.motor_busy  = arm_moving();
        return r;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [8:0] data);
        case (idx)
            REG_WAKE_PERIOD:   sh_wake_period = data[7:0];
            REG_INACT_LIMIT:   sh_inact_limit = data[4:0];
            REG_SHORT_PRESS:   sh_short_press = data;
            REG_LONG_CAP:      sh_long_cap    = data;
            REG_STEPS_GO:      sh_steps_go    = data[7:0];
            REG_STEPS_BACK:    sh_steps_back  = data[7:0];
            REG_RETRACT_STEPS: sh_retract     = data[7:0];
            default: ;
        endcase
    endfunction

    // send one tick word; push stays high for a back-to-back word
    task automatic send_tick(input logic touch, input logic sens);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_touch_level  <= touch;
        i_sensor_level <= sens;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        actuator_words_due.push_back(advance_controller(touch, sens));
        items_sent++;
    endtask

    task automatic press_for(input int n, input logic sens);
        repeat (n) send_tick(1'b1, sens);
        send_tick(1'b0, sens);
    endtask

    task automatic rest_for(input int n, input logic sens);
        repeat (n) send_tick(1'b0, sens);
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (actuator_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // unused upper data bits carry random junk
    task automatic load_settings(input logic [7:0] wake, input logic [4:0] inact,
                                 input logic [8:0] short_t, input logic [8:0] cap,
                                 input logic [7:0] go, input logic [7:0] back,
                                 input logic [7:0] retract);
        logic [7:0] junk;
        junk = 8'($urandom);
        wait_for_idle();
        write_reg(REG_WAKE_PERIOD, {junk[0], wake});
        write_reg(REG_INACT_LIMIT, {junk[4:1], inact});
        write_reg(REG_SHORT_PRESS, short_t);
        write_reg(REG_LONG_CAP, cap);
        write_reg(REG_STEPS_GO, {junk[5], go});
        write_reg(REG_STEPS_BACK, {junk[6], back});
        write_reg(REG_RETRACT_STEPS, {junk[7], retract});
    endtask

    task automatic test_reset_values();
        idle_on = 1'b1;
        rest_for(2, 1'b0);
        rest_for(2, 1'b1);
        rest_for(2, 1'b0);
    endtask

    task automatic test_basic_decisions();
        load_settings(8'd2, 5'd1, 9'd3, 9'd6, 8'd0, 8'd0, 8'd0);
        rest_for(1, 1'b1);
        rest_for(1, 1'b0);
        press_for(2, 1'b0);
        press_for(2, 1'b0);
        press_for(8, 1'b0);
        rest_for(3, 1'b1);
        rest_for(8, 1'b0);
        press_for(4, 1'b0);
    endtask

    task automatic test_cap_lowered();
        load_settings(8'd2, 5'd1, 9'd4, 9'd20, 8'd0, 8'd0, 8'd0);
        rest_for(1, 1'b0);
        repeat (6) send_tick(1'b1, 1'b0);
        wait_for_idle();
        write_reg(REG_LONG_CAP, 9'd3);
        write_reg(REG_UNUSED, 9'h1FF);
        rest_for(2, 1'b0);
    endtask

    task automatic test_receiver_hold();
        load_settings(8'd1, 5'd2, 9'd3, 9'd6, 8'd1, 8'd1, 8'd1);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        idle_on = 1'b1;
    endtask

    task automatic test_random_use();
        int   k;
        int   start;
        int   action;
        int   len;
        logic sens_now;
        for (k = 0; k < 8; k++) begin
            case (k)
                0: load_settings(8'd0, 5'd31, 9'd1, 9'd1, 8'd1, 8'd0, 8'd2);
                1: load_settings(8'd3, 5'd0, 9'd8, 9'd4, 8'd0, 8'd3, 8'd0);
                default: load_settings(8'($urandom_range(1, 6)), 5'($urandom_range(0, 4)),
                                       9'($urandom_range(1, 8)), 9'($urandom_range(1, 12)),
                                       8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 3)));
            endcase
            idle_on  = (k % 3) != 2;
            sens_now = 1'($urandom_range(0, 1));
            start    = items_sent;
            while (items_sent - start < 75) begin
                action = $urandom_range(0, 9);
                if (action < 5) begin
                    press_for($urandom_range(1, sh_long_cap + 2), sens_now);
                end else if (action < 7) begin
                    if ($urandom_range(0, 1)) sens_now = !sens_now;
                    rest_for($urandom_range(1, 20), sens_now);
                end else if (action == 7) begin
                    sens_now = 1'b0;
                    len = (sh_wake_period + 1) * (sh_inact_limit + 2);
                    if (len > 60) len = 60;
                    rest_for(len, sens_now);
                end else begin
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)),
                                                            1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_extreme_settings();
        load_settings(8'd255, 5'd0, 9'd511, 9'd511, 8'd255, 8'd0, 8'd255);
        idle_on = 1'b0;
        press_for(512, 1'b0);
        rest_for(60, 1'b0);
    endtask

    // receiver: random stalls plus a long hold-off when a test requests one
    initial begin
        pop       = 1'b0;
        hold_left = 0;
        pop_gap   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
                got.coil_pattern = o_coil_pattern;
                got.light_is_on  = o_light_is_on;
                got.auto_mode    = o_auto_mode;
                got.motor_busy   = o_motor_busy;
                pop_gap = idle_on ? $urandom_range(0, 14) : 0;
                if (actuator_words_due.size() == 0) begin
                    flag_mismatch("result word with nothing due");
                end else begin
                    want = actuator_words_due.pop_front();
                    if (got.coil_pattern !== want.coil_pattern)
                        flag_mismatch($sformatf("coil_pattern %h, want %h",
                                                got.coil_pattern, want.coil_pattern));
                    if (got.light_is_on !== want.light_is_on)
                        flag_mismatch($sformatf("light_is_on %b, want %b",
                                                got.light_is_on, want.light_is_on));
                    if (got.auto_mode !== want.auto_mode)
                        flag_mismatch($sformatf("auto_mode %b, want %b",
                                                got.auto_mode, want.auto_mode));
                    if (got.motor_busy !== want.motor_busy)
                        flag_mismatch($sformatf("motor_busy %b, want %b",
                                                got.motor_busy, want.motor_busy));
                end
            end
        end
    end

    initial begin
        int guard;
        clear_controller();
        err_count      = 0;
        items_sent     = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_touch_level  = 1'b0;
        i_sensor_level = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_basic_decisions();
        test_cap_lowered();
        test_receiver_hold();
        test_random_use();
        test_extreme_settings();

        @(negedge i_clk);
        push <= 1'b0;
        guard = 0;
        while (actuator_words_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (actuator_words_due.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived", actuator_words_due.size()));
        if (err_count == 0) begin
            $display("[occupancy_light_actuator_controller_top] OK");
        end else begin
            $display("[occupancy_light_actuator_controller_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/olac_pkg.sv
rtl/core/olac_front.sv
rtl/core/olac_back.sv
rtl/core/occupancy_light_actuator_controller_top.sv
rtl/core/olac_checker.sv
verif/tb.sv
